// ===== hdl/mdp_pkg.sv =====
// Shared types and constants for the minimum delta-phi pair trigger.
// Used by mdp_cell and by the top level; depends on nothing else.

package mdp_pkg;

  // Field widths of the transactions and registers.
  localparam int ET_W       = 10;
  localparam int AZ_W       = 6;
  localparam int DIST_W     = 6;
  localparam int LEAD_W     = 5;
  localparam int WIN_W      = 4;
  localparam int DEC_W      = 3;
  localparam int THR_REGS   = 3;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_SECOND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_ZERO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_ONE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO     = 3'd6;

  // Token that walks the cell chain: one list-one object and its row minimum.
  typedef struct packed {
    logic              valid;
    logic              row_en;
    logic              found;
    logic [AZ_W-1:0]   phi;
    logic [DIST_W-1:0] best_dist;
  } mdp_tok_t;

endpackage

// ===== hdl/min_delta_phi_pair_trigger_unit.sv =====
// Top level of the minimum delta-phi pair trigger: object loading, row
// injection, the chain of mdp_cell instances and the final combiner.
// Depends on mdp_pkg and mdp_cell.

// Objects are taken one per clock while busy is low. The object marked
// end_of_event starts the pair scan, and busy stays high until its last row
// has left the chain: list-one objects enter a chain of MAX_OBJECTS cells
// (one per list-two slot) one per cycle, and each passes through the
// register of every cell. The result appears on the out_ ports, flagged by
// out_valid for exactly one cycle, in the first cycle that busy is low again.
// The receiver cannot stall it, and a new object may be started in that same
// cycle.

module min_delta_phi_pair_trigger_unit #(
  parameter int MAX_OBJECTS   = 16,
  parameter int PHI_BINS      = 64,
  parameter int NUM_DECISIONS = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_list_select,
  input  logic [mdp_pkg::ET_W-1:0]       in_energy,
  input  logic [mdp_pkg::AZ_W-1:0]       in_azimuth,
  input  logic                           in_end_of_event,
  output logic                           out_valid,
  output logic [mdp_pkg::DEC_W-1:0]      out_decision_bits,
  output logic [mdp_pkg::DIST_W-1:0]     out_min_distance,
  output logic                           out_pair_found,
  output logic [mdp_pkg::WIN_W-1:0]      out_winner_first,
  output logic [mdp_pkg::WIN_W-1:0]      out_winner_second,
  input  logic                           cfg_we,
  input  logic [mdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mdp_pkg::*;

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam int NW    = (CNT_W > LEAD_W) ? CNT_W : LEAD_W;
  localparam int ND    = (NUM_DECISIONS < THR_REGS) ? NUM_DECISIONS : THR_REGS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Configuration registers.
  logic [LEAD_W-1:0] lead1_r, lead2_r;
  logic [ET_W-1:0]   cut1_r, cut2_r;
  logic [DIST_W-1:0] thr_r [THR_REGS];

  // Control state.
  logic             state_r;
  logic [CNT_W-1:0] fill1_r, fill2_r;
  logic [CNT_W-1:0] inj_cnt_r;
  logic [IDX_W-1:0] row_cnt_r;
  logic             out_valid_r;

  // List-one shift line.
  logic [ET_W-1:0] line_e_r   [MAX_OBJECTS];
  logic [AZ_W-1:0] line_phi_r [MAX_OBJECTS];

  // Chain wiring.
  mdp_tok_t         tok   [MAX_OBJECTS+1];
  logic [IDX_W-1:0] idx   [MAX_OBJECTS+1];
  logic [MAX_OBJECTS-1:0] wr2;
  logic [MAX_OBJECTS-1:0] slot_en;

  // Combiner and result.
  logic              g_found_r, g_found_nxt;
  logic [DIST_W-1:0] g_dist_r, g_dist_nxt;
  logic [IDX_W-1:0]  g_i_r, g_i_nxt;
  logic [IDX_W-1:0]  g_j_r, g_j_nxt;
  logic [DIST_W-1:0] thr_min;
  logic [DEC_W-1:0]  dec_nxt, dec_r;
  logic [DIST_W-1:0] mind_nxt, mind_r;
  logic [WIN_W-1:0]  win1_nxt, win1_r, win2_nxt, win2_r;
  logic              found_r;

  logic              accept, load1, load2, inject, consume, finish;
  logic [AZ_W-1:0]   phi_red;
  logic [NW-1:0]     n1, n2;

  assign busy   = (state_r == ST_SCAN);
  assign accept = start && !busy;
  assign load1  = accept && !in_list_select && (fill1_r < CNT_W'(MAX_OBJECTS));
  assign load2  = accept && in_list_select && (fill2_r < CNT_W'(MAX_OBJECTS));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead1_r  <= LEAD_W'(9);
      lead2_r  <= LEAD_W'(9);
      cut1_r   <= ET_W'(1);
      cut2_r   <= ET_W'(1);
      thr_r[0] <= '0;
      thr_r[1] <= '0;
      thr_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEAD_FIRST:  lead1_r  <= cfg_data[LEAD_W-1:0];
        CFG_LEAD_SECOND: lead2_r  <= cfg_data[LEAD_W-1:0];
        CFG_CUT_FIRST:   cut1_r   <= cfg_data[ET_W-1:0];
        CFG_CUT_SECOND:  cut2_r   <= cfg_data[ET_W-1:0];
        CFG_THR_ZERO:    thr_r[0] <= cfg_data[DIST_W-1:0];
        CFG_THR_ONE:     thr_r[1] <= cfg_data[DIST_W-1:0];
        CFG_THR_TWO:     thr_r[2] <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Fold the incoming phi bin into the ring by restoring subtraction.
  always_comb begin
    phi_red = in_azimuth;
    for (int k = 2; k >= 0; k--) begin
      if (int'(phi_red) >= (PHI_BINS << k)) begin
        phi_red = phi_red - AZ_W'(PHI_BINS << k);
      end
    end
  end

  // Number of leading objects actually scanned in each list.
  assign n1 = (NW'(lead1_r) < NW'(fill1_r)) ? NW'(lead1_r) : NW'(fill1_r);
  assign n2 = (NW'(lead2_r) < NW'(fill2_r)) ? NW'(lead2_r) : NW'(fill2_r);

  assign inject = (state_r == ST_SCAN) && (inj_cnt_r < CNT_W'(MAX_OBJECTS));

  // List-one line: written at the fill position, shifted toward the head
  // while rows are injected.
  for (genvar k = 0; k < MAX_OBJECTS; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (load1 && (fill1_r[IDX_W-1:0] == IDX_W'(k))) begin
        line_e_r[k]   <= in_energy;
        line_phi_r[k] <= phi_red;
      end else if (inject) begin
        if (k < MAX_OBJECTS - 1) begin
          line_e_r[k]   <= line_e_r[(k + 1) % MAX_OBJECTS];
          line_phi_r[k] <= line_phi_r[(k + 1) % MAX_OBJECTS];
        end
      end
    end
  end

  // Row token entering the chain.
  always_comb begin
    tok[0].valid     = inject;
    tok[0].row_en    = (NW'(inj_cnt_r) < n1) && (line_e_r[0] > cut1_r);
    tok[0].found     = 1'b0;
    tok[0].phi       = line_phi_r[0];
    tok[0].best_dist = '0;
    idx[0]           = '0;
  end

  // Chain of list-two cells.
  for (genvar j = 0; j < MAX_OBJECTS; j++) begin : g_chain
    assign wr2[j]     = load2 && (fill2_r[IDX_W-1:0] == IDX_W'(j));
    assign slot_en[j] = NW'(j) < n2;

    mdp_cell #(
      .PHI_BINS (PHI_BINS),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr_en      (wr2[j]),
      .wr_energy  (in_energy),
      .wr_phi     (phi_red),
      .slot_en    (slot_en[j]),
      .cut        (cut2_r),
      .slot_index (IDX_W'(j)),
      .tok_i      (tok[j]),
      .idx_i      (idx[j]),
      .tok_o      (tok[j+1]),
      .idx_o      (idx[j+1])
    );
  end

  assign consume = (state_r == ST_SCAN) && tok[MAX_OBJECTS].valid;
  assign finish  = consume && (row_cnt_r == IDX_W'(MAX_OBJECTS - 1));

  // Rows leave the chain in order; strictly smaller keeps the first pair.
  always_comb begin
    g_found_nxt = g_found_r;
    g_dist_nxt  = g_dist_r;
    g_i_nxt     = g_i_r;
    g_j_nxt     = g_j_r;
    if (consume && tok[MAX_OBJECTS].found &&
        (!g_found_r || (tok[MAX_OBJECTS].best_dist < g_dist_r))) begin
      g_found_nxt = 1'b1;
      g_dist_nxt  = tok[MAX_OBJECTS].best_dist;
      g_i_nxt     = row_cnt_r;
      g_j_nxt     = idx[MAX_OBJECTS];
    end
  end

  // Smallest threshold in use, reported when no pair qualified.
  always_comb begin
    thr_min = thr_r[0];
    for (int k = 1; k < ND; k++) begin
      if (thr_r[k] < thr_min) begin
        thr_min = thr_r[k];
      end
    end
  end

  // Decision bits and result fields.
  always_comb begin
    dec_nxt  = '0;
    mind_nxt = thr_min;
    win1_nxt = '0;
    win2_nxt = '0;
    if (g_found_nxt) begin
      mind_nxt = g_dist_nxt;
      win1_nxt = WIN_W'(g_i_nxt);
      win2_nxt = WIN_W'(g_j_nxt);
      for (int k = 0; k < ND; k++) begin
        dec_nxt[k] = g_dist_nxt > thr_r[k];
      end
    end
  end

  // Sequencing of load and scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill1_r     <= '0;
      fill2_r     <= '0;
      inj_cnt_r   <= '0;
      row_cnt_r   <= '0;
      g_found_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= finish;
      if (load1) begin
        fill1_r <= fill1_r + CNT_W'(1);
      end
      if (load2) begin
        fill2_r <= fill2_r + CNT_W'(1);
      end
      if (inject) begin
        inj_cnt_r <= inj_cnt_r + CNT_W'(1);
      end
      if (consume) begin
        row_cnt_r <= row_cnt_r + IDX_W'(1);
      end
      if (accept && in_end_of_event) begin
        state_r   <= ST_SCAN;
        inj_cnt_r <= '0;
        row_cnt_r <= '0;
        g_found_r <= 1'b0;
      end else begin
        g_found_r <= g_found_nxt;
      end
      if (finish) begin
        state_r <= ST_IDLE;
        fill1_r <= '0;
        fill2_r <= '0;
      end
    end
  end

  // Running minimum and result payload.
  always_ff @(posedge clk) begin
    g_dist_r <= g_dist_nxt;
    g_i_r    <= g_i_nxt;
    g_j_r    <= g_j_nxt;
    if (finish) begin
      dec_r   <= dec_nxt;
      mind_r  <= mind_nxt;
      found_r <= g_found_nxt;
      win1_r  <= win1_nxt;
      win2_r  <= win2_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decision_bits = dec_r;
  assign out_min_distance  = mind_r;
  assign out_pair_found    = found_r;
  assign out_winner_first  = win1_r;
  assign out_winner_second = win2_r;

  // A result strobe never lasts longer than one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The end of a scan always delivers its result.
  a_scan_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("scan finished without a result");

  // Tokens leave the chain only while a scan is running.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MAX_OBJECTS].valid |-> (state_r == ST_SCAN))
    else $error("row token left the chain outside a scan");

  // The last object of an event starts a scan.
  a_eoe_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_end_of_event) |=> busy)
    else $error("end of event did not start the scan");

endmodule

// ===== hdl/mdp_cell.sv =====
// One cell of the pair-scan chain: holds one list-two object and updates
// the passing row token with its phi distance. Depends on mdp_pkg.

module mdp_cell #(
  parameter int PHI_BINS = 64,
  parameter int IDX_W    = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [mdp_pkg::ET_W-1:0] wr_energy,
  input  logic [mdp_pkg::AZ_W-1:0] wr_phi,
  input  logic                     slot_en,
  input  logic [mdp_pkg::ET_W-1:0] cut,
  input  logic [IDX_W-1:0]         slot_index,
  input  mdp_pkg::mdp_tok_t        tok_i,
  input  logic [IDX_W-1:0]         idx_i,
  output mdp_pkg::mdp_tok_t        tok_o,
  output logic [IDX_W-1:0]         idx_o
);
  import mdp_pkg::*;

  localparam int PW = $clog2(PHI_BINS + 1);
  localparam int CW = (PW > AZ_W) ? PW : AZ_W;

  logic [ET_W-1:0]   energy_r;
  logic [AZ_W-1:0]   phi_r;
  logic [AZ_W-1:0]   diff;
  logic [CW-1:0]     diff_ext;
  logic [CW-1:0]     wrap;
  logic [DIST_W-1:0] pair_dist;
  logic              take;
  mdp_tok_t          tok_nxt;
  logic [IDX_W-1:0]  idx_nxt;
  mdp_tok_t          tok_r;
  logic [IDX_W-1:0]  idx_r;

  // Stored list-two object, written at most once per event.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      energy_r <= wr_energy;
      phi_r    <= wr_phi;
    end
  end

  // Circular distance: the shorter way around the ring of phi bins.
  always_comb begin
    diff      = (tok_i.phi >= phi_r) ? (tok_i.phi - phi_r) : (phi_r - tok_i.phi);
    diff_ext  = CW'(diff);
    wrap      = CW'(PHI_BINS) - diff_ext;
    pair_dist = (diff_ext < wrap) ? diff : wrap[DIST_W-1:0];
  end

  // Strictly smaller wins, so the earliest pair is kept on a tie.
  always_comb begin
    take = tok_i.valid && tok_i.row_en && slot_en && (energy_r > cut) &&
           (!tok_i.found || (pair_dist < tok_i.best_dist));
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_dist = pair_dist;
      idx_nxt           = slot_index;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule
